// ===== rtl/pdwt_pkg.sv =====
// Types and constants shared by the pulse-distance word transmitter modules.
`timescale 1ns / 1ps
`default_nettype none
package pdwt_pkg;

   localparam int unsigned WORD_BITS = 16;

   // Interval lengths in pulse units.
   localparam logic [1:0] UNITS_NONE  = 2'd0;
   localparam logic [1:0] UNITS_ZERO  = 2'd1;
   localparam logic [1:0] UNITS_ONE   = 2'd2;
   localparam logic [1:0] UNITS_INTRO = 2'd3;

   typedef enum logic {
      CMD_EVENT = 1'b0,
      CMD_PUSH  = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      logic                 operation;
      logic [WORD_BITS-1:0] data_word;
   } req_type;

   typedef struct packed {
      logic [1:0] interval_units;
      logic       line_phase;
      logic       push_accepted;
      logic [3:0] queue_count;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [WORD_BITS-1:0] word;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/pdwt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pdwt_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/pdwt_front.sv =====
// Front end: accepts request items, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module pdwt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pdwt_pkg::req_type req_data,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output pdwt_pkg::cmd_type      cmd_data
);
   import pdwt_pkg::*;

   cmd_type    entry_ff [2];
   cmd_type    cmd_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   always_comb begin
      cmd_in.kind = req_data.operation ? CMD_PUSH : CMD_EVENT;
      cmd_in.word = req_data.data_word;
   end

   assign req_ready = (count_ff != 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/pdwt_back.sv =====
// Back end: word queue, line phase and bit sequencing, with the result register.
`timescale 1ns / 1ps
`default_nettype none
module pdwt_back #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              hold_mode,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire pdwt_pkg::cmd_type cmd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pdwt_pkg::rsp_type      rsp_data
);
   import pdwt_pkg::*;

   localparam int unsigned ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned BIT_W   = $clog2(WORD_BITS);
   localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(WORD_BITS - 1);

   function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] ptr);
      logic [ADDR_W-1:0] result;
      if (ptr == ADDR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + ADDR_W'(1);
      end
      return result;
   endfunction

   logic                 phase_ff, phase_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [BIT_W-1:0]     bits_ff, bits_in;
   logic                 intro_ff, intro_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [ADDR_W-1:0]    tail_ff, tail_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 load_pending_ff, load_pending_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 cmd_take;
   logic                 queue_full;
   logic [1:0]           units;
   logic                 accepted;
   logic                 ram_we;
   logic                 ram_re;
   logic [WORD_BITS-1:0] ram_rd_data;

   assign cmd_ready  = !rsp_valid_ff || rsp_ready;
   assign cmd_take   = cmd_valid && cmd_ready;
   assign queue_full = (fill_ff == FILL_W'(QUEUE_DEPTH));

   always_comb begin
      phase_in        = phase_ff;
      word_in         = word_ff;
      bits_in         = bits_ff;
      intro_in        = intro_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      fill_in         = fill_ff;
      load_pending_in = 1'b0;
      units           = UNITS_NONE;
      accepted        = 1'b0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;

      // A popped word arrives from the RAM in the cycle after the pop; the next
      // item after a pop is never a low phase, so it is in place in time.
      if (load_pending_ff) begin
         word_in = ram_rd_data;
      end

      if (cmd_take) begin
         case (cmd_data.kind)
            CMD_PUSH: begin
               if (!queue_full) begin
                  ram_we   = 1'b1;
                  tail_in  = next_ptr(tail_ff);
                  fill_in  = fill_ff + FILL_W'(1);
                  accepted = 1'b1;
               end
            end
            CMD_EVENT: begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  units    = UNITS_ZERO;
               end else begin
                  phase_in = 1'b0;
                  if (word_ff != '0) begin
                     if (intro_ff) begin
                        units   = word_ff[BIT_TOP - bits_ff] ? UNITS_ONE : UNITS_ZERO;
                        bits_in = bits_ff + BIT_W'(1);
                        if (bits_ff == BIT_TOP) begin
                           bits_in  = '0;
                           word_in  = '0;
                           intro_in = 1'b0;
                        end
                     end else begin
                        units    = UNITS_INTRO;
                        intro_in = 1'b1;
                     end
                  end else if (hold_mode) begin
                     units = UNITS_ONE;
                  end else begin
                     units = UNITS_ZERO;
                     if (fill_ff != '0) begin
                        ram_re          = 1'b1;
                        head_in         = next_ptr(head_ff);
                        fill_in         = fill_ff - FILL_W'(1);
                        load_pending_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp_data_in.interval_units = units;
      rsp_data_in.line_phase     = phase_in;
      rsp_data_in.push_accepted  = accepted;
      rsp_data_in.queue_count    = 4'(fill_in);
      rsp_valid_in               = cmd_take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= 1'b0;
         word_ff         <= '0;
         bits_ff         <= '0;
         intro_ff        <= 1'b0;
         head_ff         <= '0;
         tail_ff         <= '0;
         fill_ff         <= '0;
         load_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         word_ff         <= word_in;
         bits_ff         <= bits_in;
         intro_ff        <= intro_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         fill_ff         <= fill_in;
         load_pending_ff <= load_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pdwt_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (cmd_data.word),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("word queue fill count exceeds its depth");

   a_load_before_low: assert property (@(posedge clock) disable iff (reset)
      load_pending_ff |-> !(cmd_take && cmd_data.kind == CMD_EVENT && phase_ff))
      else $error("low phase taken while a popped word is still loading");

   a_push_stored: assert property (@(posedge clock) disable iff (reset)
      cmd_take && cmd_data.kind == CMD_PUSH && !queue_full
      |=> rsp_valid_ff && rsp_data_ff.push_accepted)
      else $error("push into a queue with room was not reported as stored");

   a_bits_idle: assert property (@(posedge clock) disable iff (reset)
      !intro_ff |-> bits_ff == '0)
      else $error("bit counter running before the intro gap was sent");
`endif

endmodule
`default_nettype wire

// ===== rtl/pulse_distance_word_transmitter.sv =====
// Top level of the pulse-distance word transmitter.
`timescale 1ns / 1ps
`default_nettype none
// Sends queued 16-bit words as pulse-distance code, one timer compare event
// per item, or stores a pushed word in a QUEUE_DEPTH-entry FIFO. Exactly one
// result item is returned for every request item. The block accepts one item
// per clock cycle while the result side keeps taking results. An accepted item
// is written into the front-end queue, moved from there into the back end,
// and its result is held in the result register until the receiver takes
// it. Throughput is set by the back end, which handles one item per cycle
// while its result register is free or being taken, and by the two-entry queue
// between front and back. A word popped from the FIFO is read from its RAM in
// the following cycle, before it is needed. hold_mode is written through
// csr_write_enable and takes effect from the next item.
module pulse_distance_word_transmitter #(
   parameter int unsigned QUEUE_DEPTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pdwt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pdwt_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_write_data
);
   import pdwt_pkg::*;

   logic    hold_mode_ff, hold_mode_in;
   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd_data;

   assign hold_mode_in = csr_write_enable ? csr_write_data : hold_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_mode_ff <= 1'b0;
      end else begin
         hold_mode_ff <= hold_mode_in;
      end
   end

   pdwt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   pdwt_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .hold_mode (hold_mode_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the pulse-distance word transmitter: random items against a predictor.
`timescale 1ns / 1ps
module tb_top;
   import pdwt_pkg::*;

   localparam int unsigned DEPTH = 8;

   // Tracks the transmitter's state and holds the responses still owed by the block.
   class pulse_scoreboard;
      bit           hold_mode = 1'b0;
      bit           phase_high = 1'b0;
      logic [15:0]  word_in_flight = '0;
      logic [4:0]   bits_done = '0;
      bit           intro_sent = 1'b0;
      logic [15:0]  fifo [DEPTH];
      logic [2:0]   head = '0;
      logic [3:0]   fill = '0;
      rsp_type      due_rsps [$];
      int unsigned  errors = 0;

      function void accept_cmd(req_type item);
         rsp_type    rsp;
         logic [3:0] pos;
         rsp = '0;
         if (item.operation == CMD_PUSH) begin
            if (fill < DEPTH) begin
               fifo[head + fill[2:0]] = item.data_word;
               fill++;
               rsp.push_accepted = 1'b1;
            end
         end else if (!phase_high) begin
            phase_high = 1'b1;
            rsp.interval_units = UNITS_ZERO;
         end else begin
            phase_high = 1'b0;
            if (word_in_flight != '0) begin
               if (intro_sent) begin
                  pos = 4'd15 - bits_done[3:0];
                  rsp.interval_units = word_in_flight[pos] ? UNITS_ONE : UNITS_ZERO;
                  bits_done++;
                  if (bits_done >= WORD_BITS) begin
                     bits_done = '0;
                     word_in_flight = '0;
                     intro_sent = 1'b0;
                  end
               end else begin
                  rsp.interval_units = UNITS_INTRO;
                  intro_sent = 1'b1;
               end
            end else if (hold_mode) begin
               rsp.interval_units = UNITS_ONE;
            end else begin
               // An idle low phase pops the next word; a zero word leaves the line idle.
               rsp.interval_units = UNITS_ZERO;
               if (fill != 0) begin
                  word_in_flight = fifo[head];
                  head++;
                  fill--;
               end
            end
         end
         rsp.line_phase = phase_high;
         rsp.queue_count = fill;
         due_rsps.push_back(rsp);
      endfunction

      function void check_rsp(rsp_type got);
         rsp_type want;
         if (due_rsps.size() == 0) begin
            $error("response with none outstanding: %h", got);
            errors++;
            return;
         end
         want = due_rsps.pop_front();
         if (got.interval_units !== want.interval_units) begin
            $error("interval_units: expected %0d, got %0d", want.interval_units,
                   got.interval_units);
            errors++;
         end
         if (got.line_phase !== want.line_phase) begin
            $error("line_phase: expected %0d, got %0d", want.line_phase, got.line_phase);
            errors++;
         end
         if (got.push_accepted !== want.push_accepted) begin
            $error("push_accepted: expected %0d, got %0d", want.push_accepted,
                   got.push_accepted);
            errors++;
         end
         if (got.queue_count !== want.queue_count) begin
            $error("queue_count: expected %0d, got %0d", want.queue_count, got.queue_count);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return due_rsps.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic    csr_write_data;

   pulse_scoreboard sb = new();
   int unsigned     stall_requests;

   pulse_distance_word_transmitter #(
      .QUEUE_DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Result side: checks every accepted item and stalls on a pattern of its own.
   initial begin
      int unsigned quiet_left;
      int unsigned rx_cycle;
      int unsigned stall_seen;
      int unsigned rx_mode;
      quiet_left = 0;
      rx_cycle = 0;
      stall_seen = 0;
      rx_mode = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_rsp(rsp_data);
         end
         if (stall_seen != stall_requests) begin
            stall_seen = stall_requests;
            quiet_left = 80;
         end
         if (rx_cycle % 48 == 0) begin
            rx_mode = $urandom_range(0, 3);
         end
         rx_cycle++;
         if (quiet_left != 0) begin
            quiet_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ready <= ((rx_cycle % 5) < 3);
               default: rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   task automatic send_item(input req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.accept_cmd(item);
   endtask

   function automatic req_type make_item(input int unsigned push_pct);
      req_type item;
      item.operation = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_EVENT;
      case ($urandom_range(0, 7))
         0: item.data_word = 16'h0000;
         1: item.data_word = 16'hFFFF;
         default: item.data_word = 16'($urandom());
      endcase
      return item;
   endfunction

   task automatic send_stream(input int unsigned count, input int unsigned push_pct);
      int unsigned burst;
      int unsigned gap;
      burst = 0;
      repeat (count) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         send_item(make_item(push_pct));
         burst--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // The register may only change once the block has gone quiet.
   task automatic set_hold(input bit value);
      drain();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.hold_mode = value;
   endtask

   initial begin
      req_type     item;
      logic [15:0] fill_words [9];
      fill_words = '{16'h0000, 16'hFFFF, 16'h8001, 16'h5555, 16'hAAAA,
                     16'h0001, 16'h7FFE, 16'h8000, 16'h1234};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= 1'b0;
      stall_requests <= 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_hold(1'b0);

      // Fill the queue, overflow it once, then pop the zero word and start sending the next one.
      foreach (fill_words[i]) begin
         item.operation = CMD_PUSH;
         item.data_word = fill_words[i];
         send_item(item);
      end
      repeat (16) begin
         item.operation = CMD_EVENT;
         item.data_word = 16'($urandom());
         send_item(item);
      end

      set_hold(1'b1);
      send_stream(150, 30);

      set_hold(1'b0);
      // Keep offering items while the result side holds off, so that the input backs up.
      stall_requests <= stall_requests + 1;
      repeat (40) send_item(make_item(25));
      send_stream(250, 25);

      set_hold(1'b1);
      send_stream(100, 10);

      set_hold(1'b0);
      send_stream(250, 20);

      drain();
      repeat (10) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d responses never arrived", sb.outstanding());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
